@@ rtl/round_robin_run_list_top_assert.svh @@
// Assertion macros for the round-robin run list.
// Used by round_robin_run_list_top; depends on nothing else.
`ifndef ROUND_ROBIN_RUN_LIST_TOP_ASSERT_SVH
`define ROUND_ROBIN_RUN_LIST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, switched off while reset is asserted.
`define RRL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("run list assertion failed");
// Checked property that also holds during reset.
`define RRL_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("run list invariant failed");
`else
`define RRL_ASSERT(lbl, clk, rst_n, prop)
`define RRL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/rrl_pkg.sv @@
// Shared types and constants of the round-robin run list.
// Used by the interfaces, the list cell and the top level.
package rrl_pkg;

	localparam int unsigned ID_W = 15;
	localparam int unsigned REQ_W = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned LIST_DEPTH_DEF = 64;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ  = 2'd0,
		REQ_DEQ  = 2'd1,
		REQ_PICK = 2'd2
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	// Controls broadcast from the sequencer to every cell.
	typedef struct packed {
		logic            cmp_en;
		logic            enq_en;
		logic            deq_en;
		logic [ID_W-1:0] id;
	} cell_ctrl_t;

endpackage

@@ rtl/rrl_if.sv @@
// Request and response channel interfaces of the round-robin run list.
// Depends on rrl_pkg.
interface rrl_req_if import rrl_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [REQ_W-1:0] req_type;
	logic [ID_W-1:0]  task_id;

	modport source (output valid, output req_type, output task_id, input ready);
	modport sink (input valid, input req_type, input task_id, output ready);
endinterface

interface rrl_rsp_if import rrl_pkg::*; #(
	parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) ();
	localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                pick_valid;
	logic [ID_W-1:0]     picked_task;
	logic [CNT_W-1:0]    run_count;

	modport source (output valid, output status, output pick_valid,
		output picked_task, output run_count, input ready);
	modport sink (input valid, input status, input pick_valid,
		input picked_task, input run_count, output ready);
endinterface

@@ rtl/rrl_cell.sv @@
// One cell of the run list: holds a single task id and its compare result.
// Depends on rrl_pkg; instantiated in a row by round_robin_run_list_top.
module rrl_cell import rrl_pkg::*; #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned IDX_W = 6,
	parameter int unsigned CNT_W = 7
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0] count,
	input  logic [IDX_W-1:0] pick_idx,
	input  logic [ID_W-1:0]  up_entry,
	input  logic             hit_in,
	output logic             hit_out,
	output logic [ID_W-1:0]  pick_data,
	output logic [ID_W-1:0]  entry
);

	localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(INDEX);
	localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(INDEX);

	logic [ID_W-1:0] entry_q;
	logic            match_q;
	logic            live;

	// The cell holds a task while its place is below the fill count.
	assign live = POS_CNT < count;

	// Compare the stored id against the request id.
	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			match_q <= live && (entry_q == ctrl.id);
		end
	end

	// Once the first match has been seen, this cell and all above it shift down.
	assign hit_out = hit_in | match_q;

	// Append writes the first free place; removal pulls the upper neighbor in.
	always_ff @(posedge clk) begin
		if (ctrl.enq_en && (POS_CNT == count)) begin
			entry_q <= ctrl.id;
		end else if (ctrl.deq_en && hit_out) begin
			entry_q <= up_entry;
		end
	end

	// Drive the stored id onto the pick bus when this place is selected.
	assign pick_data = (pick_idx == POS_IDX) ? entry_q : '0;

	// The lower neighbor takes the stored id from here when the list shifts down.
	assign entry = entry_q;

endmodule

@@ rtl/round_robin_run_list_top.sv @@
// Round-robin run list: a compacted list of runnable task ids with a pick pointer.
// Each request is captured, then every cell compares its stored id in a
// registered per-cell compare, and the list, the fill count and the response
// register are updated once no earlier response is left unaccepted; the
// first-match chain runs across the row of LIST_DEPTH cells. A
// response waits in its own register, so a new request is taken while the
// previous response is still pending. An enqueue on a full list and a dequeue
// of an id that is not in the list answer with an error status and leave the
// list alone; a pick on an empty list returns no task.
// Depends on rrl_pkg, rrl_if, rrl_cell and round_robin_run_list_top_assert.svh.
`include "round_robin_run_list_top_assert.svh"
module round_robin_run_list_top import rrl_pkg::*; #(
	parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rrl_req_if.sink    req,
	rrl_rsp_if.source  rsp
);

	localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
	localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

	state_t           state_q, state_d;
	req_type_t        op_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] last_q;
	logic             picked_before_q;
	logic [IDX_W-1:0] pick_idx_q, pick_idx_d;
	logic [CNT_W-1:0] last_inc;
	logic             commit;
	logic             found;
	logic             full;
	cell_ctrl_t       ctrl;

	logic                rsp_valid_q;
	status_t             rsp_status_q, status_d;
	logic                rsp_pick_valid_q, pick_valid_d;
	logic [ID_W-1:0]     rsp_picked_q, picked_d;
	logic [CNT_W-1:0]    rsp_count_q;

	logic [LIST_DEPTH:0]  hit_chain;
	logic [ID_W-1:0]      cell_pick [LIST_DEPTH];
	logic [ID_W-1:0]      cell_entry [LIST_DEPTH];
	logic [ID_W-1:0]      pick_or;

	// Sequencer: capture, compare, commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (!rsp_valid_q || rsp.ready) begin
					commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// Request capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= REQ_ENQ;
		end else if (req.valid && req.ready) begin
			op_q <= req_type_t'(req.req_type);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			id_q <= req.task_id;
		end
	end

	// Next pick place: the one after the last pick, or place zero on wrap or before the first pick.
	assign last_inc = CNT_W'(last_q) + CNT_W'(1);
	assign pick_idx_d = (picked_before_q && (last_inc < cnt_q)) ? IDX_W'(last_inc) : '0;

	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			pick_idx_q <= pick_idx_d;
		end
	end

	// Controls broadcast to the row of cells.
	assign full = (cnt_q == FULL_CNT);
	assign found = hit_chain[LIST_DEPTH];

	always_comb begin
		ctrl.cmp_en = (state_q == S_CMP);
		ctrl.enq_en = commit && (op_q == REQ_ENQ);
		ctrl.deq_en = commit && (op_q == REQ_DEQ) && found;
		ctrl.id = id_q;
	end

	// The row of cells; the match chain runs from place zero upward.
	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic [ID_W-1:0] up_entry;

		if (i + 1 < LIST_DEPTH) begin : g_mid
			assign up_entry = cell_entry[i + 1];
		end else begin : g_end
			assign up_entry = '0;
		end

		rrl_cell #(
			.INDEX (i),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (cnt_q),
			.pick_idx  (pick_idx_q),
			.up_entry  (up_entry),
			.hit_in    (hit_chain[i]),
			.hit_out   (hit_chain[i + 1]),
			.pick_data (cell_pick[i]),
			.entry     (cell_entry[i])
		);
	end

	// Gather the selected cell's id from the pick bus.
	always_comb begin
		pick_or = '0;
		for (int unsigned i = 0; i < LIST_DEPTH; i++) begin
			pick_or = pick_or | cell_pick[i];
		end
	end

	// Result of the request and the new fill count.
	always_comb begin
		status_d = ST_OK;
		pick_valid_d = 1'b0;
		picked_d = '0;
		cnt_d = cnt_q;
		unique case (op_q)
			REQ_ENQ: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			REQ_DEQ: begin
				if (!found) begin
					status_d = ST_MISSING;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			REQ_PICK: begin
				if (cnt_q != '0) begin
					pick_valid_d = 1'b1;
					picked_d = pick_or;
				end
			end
			default: begin
			end
		endcase
	end

	// List state and the response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			last_q <= '0;
			picked_before_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				cnt_q <= cnt_d;
				if (pick_valid_d) begin
					last_q <= pick_idx_q;
					picked_before_q <= 1'b1;
				end
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_status_q <= status_d;
			rsp_pick_valid_q <= pick_valid_d;
			rsp_picked_q <= picked_d;
			rsp_count_q <= cnt_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.pick_valid = rsp_pick_valid_q;
	assign rsp.picked_task = rsp_picked_q;
	assign rsp.run_count = rsp_count_q;

	// Checks on the sequencer and the list state.
	`RRL_ASSERT_ALWAYS(a_cnt_bound, clk, cnt_q <= FULL_CNT)
	`RRL_ASSERT(a_cmp_to_upd, clk, arst_n, state_q == S_CMP |=> state_q == S_UPD)
	`RRL_ASSERT(a_pick_in_list, clk, arst_n, (commit && pick_valid_d) |=> (CNT_W'(last_q) < cnt_q))
	`RRL_ASSERT(a_miss_keeps_cnt, clk, arst_n, (commit && op_q == REQ_DEQ && !found) |=> $stable(cnt_q))

endmodule
